// ===== rtl/sapq_pkg.sv =====
// Shared types and codes for the sorted-array priority queue.
// Holds command and status codes and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package sapq_pkg;

    // Command codes on the input channel.
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_PEEK   = 2'd2;

    // Status codes on the result channel.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_ins;   // latch value, index starts at count
        logic       load_del;   // latch value, index starts at zero
        logic       rd_prev;    // read entry at index - 1
        logic       rd_cur;     // read entry at index
        logic       rd_next;    // read entry at index + 1
        logic       wr_value;   // write value at index, count + 1
        logic       wr_up;      // write read data at index, index - 1
        logic       wr_down;    // write read data at index, index + 1
        logic       idx_inc;    // index + 1
        logic       count_dec;  // count - 1
        logic       load_out;   // capture the result item
        logic [1:0] status;     // status code for the result item
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;     // count is zero
        logic full;      // count equals the depth
        logic gt;        // held value greater than read data
        logic eq;        // held value equal to read data
        logic idx_zero;  // index is zero
        logic idx_last;  // index is the last stored entry
        logic out_free;  // result register can take an item
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/sapq_ctrl.sv =====
// Controller state machine for the sorted-array priority queue.
// Sequences insert shifts, delete searches and gap closing; uses sapq_pkg.
`default_nettype none

module sapq_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_command,
    input  wire sapq_pkg::dp_sts_t sts,
    output sapq_pkg::dp_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS_RD  = 3'd1;
    localparam logic [2:0] S_INS_CMP = 3'd2;
    localparam logic [2:0] S_DEL_RD  = 3'd3;
    localparam logic [2:0] S_DEL_CMP = 3'd4;
    localparam logic [2:0] S_SH_RD   = 3'd5;
    localparam logic [2:0] S_SH_WR   = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] status_reg;
    logic [1:0] status_next;

    assign s_ready = (state_reg == S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.status  = status_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    case (s_command)
                        sapq_pkg::CMD_INSERT: begin
                            if (sts.full) begin
                                status_next = sapq_pkg::ST_OVERFLOW;
                                state_next  = S_DONE;
                            end else begin
                                cmd.load_ins = 1'b1;
                                status_next  = sapq_pkg::ST_OK;
                                state_next   = S_INS_RD;
                            end
                        end
                        sapq_pkg::CMD_DELETE: begin
                            if (sts.empty) begin
                                status_next = sapq_pkg::ST_UNDERFLOW;
                                state_next  = S_DONE;
                            end else begin
                                cmd.load_del = 1'b1;
                                status_next  = sapq_pkg::ST_OK;
                                state_next   = S_DEL_RD;
                            end
                        end
                        default: begin
                            // Peek, and the unused code, only report.
                            status_next = sts.empty ? sapq_pkg::ST_UNDERFLOW
                                                    : sapq_pkg::ST_OK;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                // At the head the value lands in the first slot.
                if (sts.idx_zero) begin
                    cmd.wr_value = 1'b1;
                    state_next   = S_DONE;
                end else begin
                    cmd.rd_prev = 1'b1;
                    state_next  = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                // Smaller entries move one slot toward the tail.
                if (sts.gt) begin
                    cmd.wr_up  = 1'b1;
                    state_next = S_INS_RD;
                end else begin
                    cmd.wr_value = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_DEL_RD: begin
                cmd.rd_cur = 1'b1;
                state_next = S_DEL_CMP;
            end
            S_DEL_CMP: begin
                if (sts.eq) begin
                    state_next = S_SH_RD;
                end else if (sts.idx_last) begin
                    status_next = sapq_pkg::ST_NOT_FOUND;
                    state_next  = S_DONE;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_DEL_RD;
                end
            end
            S_SH_RD: begin
                // Close the gap one entry at a time.
                if (sts.idx_last) begin
                    cmd.count_dec = 1'b1;
                    state_next    = S_DONE;
                end else begin
                    cmd.rd_next = 1'b1;
                    state_next  = S_SH_WR;
                end
            end
            S_SH_WR: begin
                cmd.wr_down = 1'b1;
                state_next  = S_SH_RD;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and status registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= sapq_pkg::ST_OK;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sapq_datapath.sv =====
// Datapath for the sorted-array priority queue: entry memory, index, count,
// top-of-queue copy and the result register. Uses sapq_pkg.
`default_nettype none

module sapq_datapath #(
    parameter int DEPTH = 16,
    parameter int IW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic signed [31:0] s_value,
    input  wire sapq_pkg::dp_cmd_t  cmd,
    output sapq_pkg::dp_sts_t       sts,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic signed [31:0]      m_top_value,
    output logic                    m_top_valid,
    output logic [CW-1:0]           m_entry_count
);

    localparam logic [IW-1:0] IDX_ONE = IW'(1);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);
    localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;
    logic signed [31:0] value_reg;
    logic signed [31:0] top_reg;
    logic [IW-1:0]      idx_reg;
    logic [IW-1:0]      idx_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [IW-1:0]      rd_addr;
    logic               rd_en;
    logic               mem_we;
    logic signed [31:0] mem_wdata;
    logic               m_valid_reg;
    logic [1:0]         m_status_reg;
    logic signed [31:0] m_top_value_reg;
    logic               m_top_valid_reg;
    logic [CW-1:0]      m_entry_count_reg;

    // Read address and write port selection.
    always_comb begin
        rd_en     = cmd.rd_prev | cmd.rd_cur | cmd.rd_next;
        rd_addr   = idx_reg;
        if (cmd.rd_prev) begin
            rd_addr = idx_reg - IDX_ONE;
        end else if (cmd.rd_next) begin
            rd_addr = idx_reg + IDX_ONE;
        end
        mem_we    = cmd.wr_value | cmd.wr_up | cmd.wr_down;
        mem_wdata = cmd.wr_value ? value_reg : rd_data_reg;
    end

    // Index and count updates.
    always_comb begin
        idx_next   = idx_reg;
        count_next = count_reg;
        if (cmd.load_ins) begin
            idx_next = IW'(count_reg);
        end else if (cmd.load_del) begin
            idx_next = '0;
        end else if (cmd.wr_up) begin
            idx_next = idx_reg - IDX_ONE;
        end else if (cmd.wr_down || cmd.idx_inc) begin
            idx_next = idx_reg + IDX_ONE;
        end
        if (cmd.wr_value) begin
            count_next = count_reg + CNT_ONE;
        end else if (cmd.count_dec) begin
            count_next = count_reg - CNT_ONE;
        end
    end

    // Status back to the controller.
    always_comb begin
        sts.empty    = (count_reg == '0);
        sts.full     = (count_reg == CNT_MAX);
        sts.gt       = (value_reg > rd_data_reg);
        sts.eq       = (value_reg == rd_data_reg);
        sts.idx_zero = (idx_reg == '0);
        sts.idx_last = ((CW'(idx_reg) + CNT_ONE) == count_reg);
        sts.out_free = !m_valid_reg || m_ready;
    end

    // Entry memory with a registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[idx_reg] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Working registers; the top copy follows every write to the first slot.
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.load_ins || cmd.load_del) begin
            value_reg <= s_value;
        end
        if (mem_we && (idx_reg == '0)) begin
            top_reg <= mem_wdata;
        end
    end

    // Entry count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Result register, held until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_status_reg      <= cmd.status;
            m_top_value_reg   <= (count_reg != '0) ? top_reg : 32'sd0;
            m_top_valid_reg   <= (count_reg != '0);
            m_entry_count_reg <= count_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_top_value   = m_top_value_reg;
    assign m_top_valid   = m_top_valid_reg;
    assign m_entry_count = m_entry_count_reg;

endmodule

`default_nettype wire

// ===== rtl/sorted_array_priority_queue_core.sv =====
// Sorted-array priority queue: up to DEPTH signed 32-bit values, largest first.
// Channels: s_* takes one item per command (insert, delete, peek), m_* returns
// one result item per command with status, top value, top valid and count.
// Insert places a value before the first strictly smaller entry; delete
// removes the first equal entry and closes the gap.
// Peek and rejected commands go straight to the result stage. Insert reads
// entries from the tail toward the head, moves each smaller one a slot toward
// the tail, then writes the value. Delete reads and compares entries from the
// head, then moves each later entry a slot toward the head; a miss searches
// every entry. Entries move one at a time, each by a read followed by a
// write.
// One item is in work at a time; s_ready is high while the controller idles,
// even when a finished result still waits in the output register. The next
// item can be accepted in the same cycle that m_valid rises.
// Reset (synchronous, active low) empties the queue and drops any pending
// result; the entry memory is not cleared. When the receiver stalls, the
// result holds and the next finished item waits in the controller.
// Uses sapq_pkg, sapq_ctrl and sapq_datapath.
`default_nettype none

module sorted_array_priority_queue_core #(
    parameter int DEPTH = 16,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_command,
    input  wire logic signed [31:0] s_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic signed [31:0]      m_top_value,
    output logic                    m_top_valid,
    output logic [CW-1:0]           m_entry_count
);

    localparam int IW = $clog2(DEPTH);

    sapq_pkg::dp_cmd_t dp_cmd;
    sapq_pkg::dp_sts_t dp_sts;

    sapq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .sts       (dp_sts),
        .cmd       (dp_cmd)
    );

    sapq_datapath #(
        .DEPTH (DEPTH),
        .IW    (IW),
        .CW    (CW)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_value       (s_value),
        .cmd           (dp_cmd),
        .sts           (dp_sts),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_top_value   (m_top_value),
        .m_top_valid   (m_top_valid),
        .m_entry_count (m_entry_count)
    );

    // Only one item is in work at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item accepted while another is in work");

    // The count reported never exceeds the depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_entry_count <= CW'(DEPTH)))
        else $error("entry count beyond depth");

    // Top valid agrees with the count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_top_valid == (m_entry_count != '0)))
        else $error("top valid disagrees with count");

    // Overflow is reported only on a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == sapq_pkg::ST_OVERFLOW)) |-> (m_entry_count == CW'(DEPTH)))
        else $error("overflow reported on a queue that is not full");

    // A new result is loaded only when the output register is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.load_out |-> (!m_valid || m_ready))
        else $error("result register overwritten");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the sorted-array priority queue core.
// Drives insert, delete and peek items, predicts every result item and checks each field.
// Depends on sapq_pkg and sorted_array_priority_queue_core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 16;
    localparam int CW           = $clog2(DEPTH + 1);
    localparam int RANDOM_ITEMS = 1300;
    localparam int CYCLE_LIMIT  = 400000;
    // Command code three has no name in the package; the core treats it as a peek.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One result item: status, top value, top valid flag and entry count.
    typedef struct packed {
        logic [1:0]    status;
        logic [31:0]   top;
        logic          valid;
        logic [CW-1:0] count;
    } pq_result_t;

    // One row of the directed stimulus; typed rows carry their own expectation.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] value;
        logic        typed;
        pq_result_t  res;
    } dir_row_t;

    logic                    aclk          = 1'b0;
    logic                    aresetn       = 1'b0;
    logic                    s_valid       = 1'b0;
    logic                    s_ready;
    logic [1:0]              s_command     = sapq_pkg::CMD_PEEK;
    logic signed [31:0]      s_value       = '0;
    logic                    m_valid;
    logic                    m_ready       = 1'b0;
    logic [1:0]              m_status;
    logic signed [31:0]      m_top_value;
    logic                    m_top_valid;
    logic [CW-1:0]           m_entry_count;

    // Idle and stall percentages of the current phase.
    int idle_pct  = 0;
    int stall_pct = 0;

    int errors      = 0;
    int cycle_count = 0;
    int peak_count  = 0;
    int sent_by_cmd[4];
    int status_seen[4];

    // Own copy of the queue contents, largest first.
    logic signed [31:0] model_entries[DEPTH];
    int                 model_count = 0;

    pq_result_t expected_results[$];
    dir_row_t   dir_rows[$];

    sorted_array_priority_queue_core #(
        .DEPTH(DEPTH)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_top_value  (m_top_value),
        .m_top_valid  (m_top_valid),
        .m_entry_count(m_entry_count)
    );

    always #4 aclk = ~aclk;

    // Apply one command to the queue copy and return the result item it yields.
    function automatic pq_result_t predict_queue_step(input logic [1:0] cmd,
                                                      input logic signed [31:0] v);
        pq_result_t r;
        int pos;
        int k;
        r.status = sapq_pkg::ST_OK;
        case (cmd)
            sapq_pkg::CMD_INSERT: begin
                if (model_count >= DEPTH) begin
                    r.status = sapq_pkg::ST_OVERFLOW;
                end else begin
                    // The new value goes ahead of the first strictly smaller entry.
                    pos = model_count;
                    for (k = 0; k < model_count; k++) begin
                        if (v > model_entries[k]) begin
                            pos = k;
                            break;
                        end
                    end
                    for (k = model_count; k > pos; k--) begin
                        model_entries[k] = model_entries[k - 1];
                    end
                    model_entries[pos] = v;
                    model_count++;
                end
            end
            sapq_pkg::CMD_DELETE: begin
                if (model_count == 0) begin
                    r.status = sapq_pkg::ST_UNDERFLOW;
                end else begin
                    pos = -1;
                    for (k = 0; k < model_count; k++) begin
                        if (model_entries[k] == v) begin
                            pos = k;
                            break;
                        end
                    end
                    if (pos < 0) begin
                        r.status = sapq_pkg::ST_NOT_FOUND;
                    end else begin
                        for (k = pos; k + 1 < model_count; k++) begin
                            model_entries[k] = model_entries[k + 1];
                        end
                        model_count--;
                    end
                end
            end
            default: begin
                if (model_count == 0) begin
                    r.status = sapq_pkg::ST_UNDERFLOW;
                end
            end
        endcase
        r.valid = (model_count != 0);
        r.top   = (model_count != 0) ? model_entries[0] : 32'd0;
        r.count = CW'(model_count);
        return r;
    endfunction

    // Queue up one directed row; the valid flag follows from the count.
    task automatic add_row(input logic [1:0] cmd, input logic [31:0] value, input logic typed,
                           input logic [1:0] st, input logic [31:0] top, input int cnt);
        dir_row_t row;
        row.cmd       = cmd;
        row.value     = value;
        row.typed     = typed;
        row.res.status = st;
        row.res.top    = top;
        row.res.valid  = (cnt != 0);
        row.res.count  = CW'(cnt);
        dir_rows.push_back(row);
    endtask

    // Present one item, called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic [1:0] cmd, input logic signed [31:0] value,
                             input logic typed, input pq_result_t typed_res);
        pq_result_t pred;
        if ($urandom_range(99) < idle_pct) begin
            s_valid   <= 1'b0;
            s_command <= 2'($urandom);
            s_value   <= $urandom;
            do @(negedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_value   <= value;
        do @(posedge aclk); while (!s_ready);
        pred = predict_queue_step(cmd, value);
        expected_results.push_back(typed ? typed_res : pred);
        sent_by_cmd[cmd]++;
        if (model_count > peak_count) begin
            peak_count = model_count;
        end
        @(negedge aclk);
    endtask

    // The receiver stalls at random according to the current phase.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare each accepted result item with the oldest expectation.
    always @(posedge aclk) begin
        pq_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result item: status %0d top_value %0d count %0d",
                       m_status, m_top_value, m_entry_count);
                errors++;
            end else begin
                want = expected_results.pop_front();
                status_seen[m_status]++;
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    errors++;
                end
                if (m_top_value !== $signed(want.top)) begin
                    $error("top_value: expected %0d, got %0d", $signed(want.top), m_top_value);
                    errors++;
                end
                if (m_top_valid !== want.valid) begin
                    $error("top_valid: expected %0d, got %0d", want.valid, m_top_valid);
                    errors++;
                end
                if (m_entry_count !== want.count) begin
                    $error("entry_count: expected %0d, got %0d", want.count, m_entry_count);
                    errors++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        pq_result_t         none;
        logic [1:0]         cmd;
        logic signed [31:0] value;
        int                 pick;
        int                 sel;
        bit                 fill_heavy;

        none = '0;

        // Empty queue, extremes, a full queue and deletes of head, tail and duplicates.
        add_row(sapq_pkg::CMD_PEEK,   32'd0,         1'b1, sapq_pkg::ST_UNDERFLOW,
                32'd0,          0);
        add_row(sapq_pkg::CMD_DELETE, 32'd7,         1'b1, sapq_pkg::ST_UNDERFLOW,
                32'd0,          0);
        add_row(CMD_UNUSED,           32'hFFFF_FFFF, 1'b1, sapq_pkg::ST_UNDERFLOW,
                32'd0,          0);
        add_row(sapq_pkg::CMD_INSERT, 32'h7FFF_FFFF, 1'b1, sapq_pkg::ST_OK,
                32'h7FFF_FFFF,  1);
        add_row(sapq_pkg::CMD_INSERT, 32'h8000_0000, 1'b1, sapq_pkg::ST_OK,
                32'h7FFF_FFFF,  2);
        add_row(sapq_pkg::CMD_PEEK,   32'h1234_5678, 1'b1, sapq_pkg::ST_OK,
                32'h7FFF_FFFF,  2);
        add_row(sapq_pkg::CMD_DELETE, 32'd0,         1'b1, sapq_pkg::ST_NOT_FOUND,
                32'h7FFF_FFFF,  2);
        add_row(sapq_pkg::CMD_INSERT, 32'd0,         1'b0, sapq_pkg::ST_OK, 32'd0, 0);
        add_row(sapq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 1'b0, sapq_pkg::ST_OK, 32'd0, 0);
        add_row(sapq_pkg::CMD_INSERT, 32'd1,         1'b0, sapq_pkg::ST_OK, 32'd0, 0);
        add_row(sapq_pkg::CMD_INSERT, 32'd0,         1'b0, sapq_pkg::ST_OK, 32'd0, 0);
        add_row(sapq_pkg::CMD_INSERT, 32'd5,         1'b0, sapq_pkg::ST_OK, 32'd0, 0);
        add_row(sapq_pkg::CMD_INSERT, 32'd5,         1'b0, sapq_pkg::ST_OK, 32'd0, 0);
        add_row(sapq_pkg::CMD_INSERT, 32'hFFFF_FF9C, 1'b0, sapq_pkg::ST_OK, 32'd0, 0);
        add_row(sapq_pkg::CMD_INSERT, 32'd100,       1'b0, sapq_pkg::ST_OK, 32'd0, 0);
        add_row(sapq_pkg::CMD_INSERT, 32'h7FFF_FFFF, 1'b0, sapq_pkg::ST_OK, 32'd0, 0);
        add_row(sapq_pkg::CMD_INSERT, 32'h8000_0000, 1'b0, sapq_pkg::ST_OK, 32'd0, 0);
        add_row(sapq_pkg::CMD_INSERT, 32'h5555_5555, 1'b0, sapq_pkg::ST_OK, 32'd0, 0);
        add_row(sapq_pkg::CMD_INSERT, 32'hAAAA_AAAA, 1'b0, sapq_pkg::ST_OK, 32'd0, 0);
        add_row(sapq_pkg::CMD_INSERT, 32'd3,         1'b0, sapq_pkg::ST_OK, 32'd0, 0);
        add_row(sapq_pkg::CMD_INSERT, 32'd3,         1'b0, sapq_pkg::ST_OK, 32'd0, 0);
        add_row(sapq_pkg::CMD_INSERT, 32'd9,         1'b1, sapq_pkg::ST_OVERFLOW,
                32'h7FFF_FFFF, 16);
        add_row(sapq_pkg::CMD_DELETE, 32'h8000_0000, 1'b0, sapq_pkg::ST_OK, 32'd0, 0);
        add_row(sapq_pkg::CMD_DELETE, 32'd5,         1'b0, sapq_pkg::ST_OK, 32'd0, 0);
        add_row(sapq_pkg::CMD_DELETE, 32'h7FFF_FFFF, 1'b0, sapq_pkg::ST_OK, 32'd0, 0);

        // Synchronous reset held low from the start, released at a falling edge.
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        model_count = 0;

        // Directed part runs without idling.
        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].cmd, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].res);
        end

        // Random part in four phases of idle and stall rates; insert-heavy and
        // delete-heavy runs are picked at random so the queue repeatedly fills up and drains.
        fill_heavy = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case (n / (RANDOM_ITEMS / 4))
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 53; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 53; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            if (n % 48 == 0) begin
                fill_heavy = $urandom_range(1);
            end

            pick = $urandom_range(99);
            if (pick < 3) begin
                cmd = CMD_UNUSED;
            end else if (pick < 13) begin
                cmd = sapq_pkg::CMD_PEEK;
            end else if (pick < (fill_heavy ? 73 : 38)) begin
                cmd = sapq_pkg::CMD_INSERT;
            end else begin
                cmd = sapq_pkg::CMD_DELETE;
            end

            // Deletes mostly name a stored value; otherwise small values collide often.
            sel = $urandom_range(99);
            if (cmd == sapq_pkg::CMD_DELETE && model_count != 0 && sel < 75) begin
                value = model_entries[$urandom_range(model_count - 1)];
            end else if (sel < 55) begin
                value = 32'(int'($urandom_range(8)) - 4);
            end else if (sel < 90) begin
                value = $urandom;
            end else begin
                case ($urandom_range(3))
                    0:       value = 32'sh7FFF_FFFF;
                    1:       value = 32'sh8000_0000;
                    2:       value = 32'sh7FFF_FFFE;
                    default: value = 32'sh8000_0001;
                endcase
            end
            send_item(cmd, value, 1'b0, none);
        end
        s_valid <= 1'b0;

        // Drain, then allow time for any stray result item to show up.
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4 * DEPTH + 16) @(posedge aclk);

        $display("Sent %0d inserts, %0d deletes and %0d peeks (%0d with the spare code).",
                 sent_by_cmd[sapq_pkg::CMD_INSERT], sent_by_cmd[sapq_pkg::CMD_DELETE],
                 sent_by_cmd[sapq_pkg::CMD_PEEK] + sent_by_cmd[CMD_UNUSED],
                 sent_by_cmd[CMD_UNUSED]);
        $display("Results: %0d ok, %0d overflow, %0d underflow, %0d not found; deepest %0d of %0d.",
                 status_seen[sapq_pkg::ST_OK], status_seen[sapq_pkg::ST_OVERFLOW],
                 status_seen[sapq_pkg::ST_UNDERFLOW], status_seen[sapq_pkg::ST_NOT_FOUND],
                 peak_count, DEPTH);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
